// File: design/lcdns_pkg.sv
// Shared types and constants of the character LCD nibble sequencer.
package lcdns_pkg;

    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int COL_W     = 6;
    localparam int NIB_W     = 4;
    localparam int PRE_W     = 10;
    localparam int POST_W    = 15;
    localparam int STEP_W    = 4;
    localparam int EN_HIGH_W = 8;
    localparam int RECOV_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 10;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Request command codes
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSTR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DATA   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_REC  = 1'b1;

    localparam logic [EN_HIGH_W-1:0] EN_HIGH_RESET = 8'd3;
    localparam logic [RECOV_W-1:0]   RECOV_RESET   = 10'd50;

    // Bus values
    localparam logic [BYTE_W-1:0] LCD_FUNCSET = 8'h28;
    localparam logic [BYTE_W-1:0] LCD_DISPON  = 8'h0C;
    localparam logic [BYTE_W-1:0] LCD_ENTRY   = 8'h06;
    localparam logic [BYTE_W-1:0] LCD_CLR     = 8'h01;
    localparam logic [BYTE_W-1:0] LCD_ROW0    = 8'h80;
    localparam logic [BYTE_W-1:0] LCD_ROW1    = 8'hC0;
    localparam logic [NIB_W-1:0]  LCD_WAKE    = 4'h3;
    localparam logic [NIB_W-1:0]  LCD_MODE4   = 4'h2;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd12;

    // Controller to datapath
    typedef struct packed {
        logic              capture;
        logic              load;
        logic [STEP_W-1:0] step;
    } lcdns_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic req_known;
        logic ev_last;
    } lcdns_stat_t;

    typedef struct packed {
        logic              reg_select;
        logic [NIB_W-1:0]  nibble;
        logic              strobe;
        logic [PRE_W-1:0]  pre_wait;
        logic [POST_W-1:0] post_wait;
        logic              last;
    } lcdns_event_t;

endpackage

// File: design/lcdns_ctrl.sv
// Controller state machine: request intake and event sequencing.
module lcdns_ctrl
    import lcdns_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  lcdns_stat_t stat,
    output lcdns_ctrl_t ctrl
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t            state_reg, state_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        step_next     = step_reg;
        ctrl.capture  = 1'b0;
        ctrl.load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // drop unknown commands, start a run otherwise
                if (s_tvalid && stat.req_known) begin
                    ctrl.capture  = 1'b1;
                    ctrl.load     = 1'b1;
                    step_next     = '0;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (stat.ev_last) begin
                        m_tvalid_next = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                        ctrl.load = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ctrl.step = step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            step_reg     <= step_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input taken while an event is pending");

    a_run_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_tvalid && s_tready && stat.req_known) |=> m_tvalid)
        else $error("known command did not start a run");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && m_tvalid && m_tready && stat.ev_last) |=> (s_tready && !m_tvalid))
        else $error("run did not end after its last event");
`endif

endmodule

// File: design/lcdns_datapath.sv
// Datapath: request latch, event generation, output register, config registers.
module lcdns_datapath
    import lcdns_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  lcdns_ctrl_t          ctrl,
    output lcdns_stat_t          stat,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic [CMD_W-1:0]  cmd_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [COL_W-1:0]  col_reg;
    logic              row_reg;

    logic [CMD_W-1:0]  cmd_sel;
    logic [BYTE_W-1:0] byte_sel;
    logic [COL_W-1:0]  col_sel;
    logic              row_sel;

    lcdns_event_t ev_next, ev_reg;

    logic [EN_HIGH_W-1:0] enable_high_reg;
    logic [RECOV_W-1:0]   strobe_rec_reg;

    function automatic lcdns_event_t make_event(
        input logic [CMD_W-1:0]  cmd,
        input logic [BYTE_W-1:0] bval,
        input logic [COL_W-1:0]  col,
        input logic              row,
        input logic [STEP_W-1:0] step
    );
        lcdns_event_t      ev;
        logic [BYTE_W-1:0] b;
        logic [STEP_W-1:0] rel;
        ev  = '0;
        b   = '0;
        rel = step - 4'd5;
        case (cmd) inside
            CMD_INIT: begin
                ev.strobe = 1'b1;
                case (step)
                    4'd0: begin
                        ev.strobe    = 1'b0;
                        ev.post_wait = 15'd20000;
                    end
                    4'd1: begin
                        ev.nibble    = LCD_WAKE;
                        ev.post_wait = 15'd5000;
                    end
                    4'd2: begin
                        ev.nibble    = LCD_WAKE;
                        ev.post_wait = 15'd100;
                    end
                    4'd3: ev.nibble = LCD_WAKE;
                    4'd4: ev.nibble = LCD_MODE4;
                    default: begin
                        case (rel[2:1])
                            2'd0:    b = LCD_FUNCSET;
                            2'd1:    b = LCD_DISPON;
                            2'd2:    b = LCD_ENTRY;
                            default: b = LCD_CLR;
                        endcase
                        // odd steps carry the high nibble
                        ev.nibble = step[0] ? b[7:4] : b[3:0];
                    end
                endcase
                ev.last = (step >= INIT_LAST_STEP);
            end
            CMD_INSTR, CMD_DATA, CMD_CURSOR, CMD_CLEAR: begin
                case (cmd) inside
                    CMD_INSTR, CMD_DATA: b = bval;
                    CMD_CURSOR:          b = (row ? LCD_ROW1 : LCD_ROW0) + {2'b00, col};
                    default:             b = LCD_CLR;
                endcase
                ev.reg_select = (cmd == CMD_DATA);
                ev.strobe     = 1'b1;
                ev.nibble     = step[0] ? b[3:0] : b[7:4];
                ev.last       = step[0];
                if (cmd == CMD_CURSOR && !step[0]) begin
                    ev.pre_wait = 10'd1000;
                end
                if (step[0]) begin
                    if (cmd == CMD_CURSOR) begin
                        ev.post_wait = 15'd50;
                    end else if (cmd == CMD_CLEAR) begin
                        ev.post_wait = 15'd10;
                    end
                end
            end
            default: ev.last = 1'b1;
        endcase
        return ev;
    endfunction

    // use the incoming request on the capture cycle, the held one after
    always_comb begin
        if (ctrl.capture) begin
            cmd_sel  = s_tdata[2:0];
            byte_sel = s_tdata[10:3];
            col_sel  = s_tdata[16:11];
            row_sel  = s_tdata[17];
        end else begin
            cmd_sel  = cmd_reg;
            byte_sel = byte_reg;
            col_sel  = col_reg;
            row_sel  = row_reg;
        end
        ev_next = make_event(cmd_sel, byte_sel, col_sel, row_sel, ctrl.step);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg  <= cmd_sel;
            byte_reg <= byte_sel;
            col_reg  <= col_sel;
            row_reg  <= row_sel;
        end
        if (ctrl.load) begin
            ev_reg <= ev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_high_reg <= EN_HIGH_RESET;
            strobe_rec_reg  <= RECOV_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENABLE_HIGH: enable_high_reg <= cfg_data[EN_HIGH_W-1:0];
                CFG_STROBE_REC:  strobe_rec_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign stat.req_known = (s_tdata[2:0] <= CMD_CLEAR);
    assign stat.ev_last   = ev_reg.last;

    assign m_tdata = {2'b00, ev_reg.post_wait, ev_reg.pre_wait, ev_reg.strobe, ev_reg.nibble};
    assign m_tuser = ev_reg.reg_select;
    assign m_tlast = ev_reg.last;

`ifndef SYNTH
    a_cfg_en_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cfg_valid && cfg_ready && cfg_index == CFG_ENABLE_HIGH)
        |=> (enable_high_reg == $past(cfg_data[EN_HIGH_W-1:0])))
        else $error("enable high time write lost");

    a_cfg_recov: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cfg_valid && cfg_ready && cfg_index == CFG_STROBE_REC)
        |=> (strobe_rec_reg == $past(cfg_data)))
        else $error("strobe recovery write lost");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config channel not ready");
`endif

endmodule

// File: design/char_lcd_nibble_sequencer_unit.sv
// Top level of the character LCD 4-bit bus sequencer.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------
//  s_       | in        | s_tvalid / s_tready | s_tdata: command, byte, column, row
//  m_       | out       | m_tvalid / m_tready | m_tdata, m_tuser (RS), m_tlast
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A request enters through the s_ handshake; each event then occupies the output
//  register until it transfers: init is 13 events, the other commands 2, unknown
//  codes 0. The controller steps one event per output transfer.
//  Reset (aresetn low, synchronous) idles the controller and loads the timing
//  registers with 3 us enable high and 50 us strobe recovery.
//  A stalled output holds its event; no new request is taken until the run's last
//  event has transferred. cfg_ready is always high.
module char_lcd_nibble_sequencer_unit
    import lcdns_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // command [2:0], byte_value [10:3], column [16:11], row [17], zero [23:18]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // nibble [3:0], strobe_res [4], pre_wait_us [14:5], post_wait_us [29:15], zero [31:30]
    output logic [M_TDATA_W-1:0] m_tdata,
    // reg_select [0]
    output logic                 m_tuser,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    lcdns_ctrl_t ctrl;
    lcdns_stat_t stat;

    // sequencing: request intake, step count, output valid
    lcdns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // event values, request hold, timing registers
    lcdns_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .ctrl      (ctrl),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: tb/lcd_bus_event_checker.sv
// Checker for the LCD nibble sequencer: predicts bus events per request and compares.
`timescale 1ns / 100ps

module lcd_bus_event_checker
    import lcdns_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    input  logic                 m_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int unsigned          fail_total,
    output int unsigned          events_pending
);

    localparam logic [POST_W-1:0] POWER_SETTLE_US = 15'd20000;
    localparam logic [POST_W-1:0] WAKE_FIRST_US   = 15'd5000;
    localparam logic [POST_W-1:0] WAKE_SECOND_US  = 15'd100;
    localparam logic [PRE_W-1:0]  CURSOR_PRE_US   = 10'd1000;
    localparam logic [POST_W-1:0] CURSOR_POST_US  = 15'd50;
    localparam logic [POST_W-1:0] CLEAR_POST_US   = 15'd10;

    lcdns_event_t lcd_event_q[$];
    lcdns_event_t run_events[$];

    // Timing registers; no event field depends on them.
    logic [EN_HIGH_W-1:0] enable_high_us;
    logic [RECOV_W-1:0]   recovery_us;

    initial begin
        fail_total     = 0;
        events_pending = 0;
    end

    function automatic void stage_event(logic rs, logic [NIB_W-1:0] nib, logic strobe,
                                        logic [PRE_W-1:0] pre, logic [POST_W-1:0] post);
        lcdns_event_t ev;
        ev.reg_select = rs;
        ev.nibble     = nib;
        ev.strobe     = strobe;
        ev.pre_wait   = pre;
        ev.post_wait  = post;
        ev.last       = 1'b0;
        run_events.push_back(ev);
    endfunction

    // High nibble first, both strobed.
    function automatic void stage_byte(logic rs, logic [BYTE_W-1:0] value,
                                       logic [PRE_W-1:0] pre, logic [POST_W-1:0] post);
        stage_event(rs, value[7:4], 1'b1, pre, '0);
        stage_event(rs, value[3:0], 1'b1, '0, post);
    endfunction

    function automatic void predict_bus_run(logic [S_TDATA_W-1:0] req);
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] byte_val;
        logic [COL_W-1:0]  col;
        logic              row_sel;
        logic [BYTE_W-1:0] addr;
        lcdns_event_t      tail;
        cmd      = req[CMD_W-1:0];
        byte_val = req[CMD_W +: BYTE_W];
        col      = req[CMD_W+BYTE_W +: COL_W];
        row_sel  = req[CMD_W+BYTE_W+COL_W];
        run_events.delete();
        case (cmd)
            CMD_INIT: begin
                stage_event(1'b0, '0, 1'b0, '0, POWER_SETTLE_US);
                stage_event(1'b0, LCD_WAKE, 1'b1, '0, WAKE_FIRST_US);
                stage_event(1'b0, LCD_WAKE, 1'b1, '0, WAKE_SECOND_US);
                stage_event(1'b0, LCD_WAKE, 1'b1, '0, '0);
                stage_event(1'b0, LCD_MODE4, 1'b1, '0, '0);
                stage_byte(1'b0, LCD_FUNCSET, '0, '0);
                stage_byte(1'b0, LCD_DISPON, '0, '0);
                stage_byte(1'b0, LCD_ENTRY, '0, '0);
                stage_byte(1'b0, LCD_CLR, '0, '0);
            end
            CMD_INSTR:  stage_byte(1'b0, byte_val, '0, '0);
            CMD_DATA:   stage_byte(1'b1, byte_val, '0, '0);
            CMD_CURSOR: begin
                addr = (row_sel ? LCD_ROW1 : LCD_ROW0) + {2'b00, col};
                stage_byte(1'b0, addr, CURSOR_PRE_US, CURSOR_POST_US);
            end
            CMD_CLEAR:  stage_byte(1'b0, LCD_CLR, '0, CLEAR_POST_US);
            default: ;  // unknown codes produce nothing
        endcase
        if (run_events.size() != 0) begin
            tail      = run_events[run_events.size()-1];
            tail.last = 1'b1;
            run_events[run_events.size()-1] = tail;
            foreach (run_events[i]) lcd_event_q.push_back(run_events[i]);
        end
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge aclk) begin
        lcdns_event_t want;
        if (!aresetn) begin
            lcd_event_q.delete();
            enable_high_us = EN_HIGH_RESET;
            recovery_us    = RECOV_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ENABLE_HIGH)
                    enable_high_us = cfg_data[EN_HIGH_W-1:0];
                else if (cfg_index == CFG_STROBE_REC)
                    recovery_us = cfg_data[RECOV_W-1:0];
            end
            if (s_tvalid && s_tready)
                predict_bus_run(s_tdata);
            if (m_tvalid && m_tready) begin
                if (lcd_event_q.size() == 0) begin
                    $error("unexpected bus event: nibble %0h rs %0b last %0b",
                           m_tdata[3:0], m_tuser, m_tlast);
                    fail_total++;
                end else begin
                    want = lcd_event_q.pop_front();
                    check_field("reg_select", want.reg_select, m_tuser);
                    check_field("nibble", want.nibble, m_tdata[3:0]);
                    check_field("strobe_res", want.strobe, m_tdata[4]);
                    check_field("pre_wait_us", want.pre_wait, m_tdata[14:5]);
                    check_field("post_wait_us", want.post_wait, m_tdata[29:15]);
                    check_field("last", want.last, m_tlast);
                    check_field("m_tdata pad", 0, m_tdata[M_TDATA_W-1:30]);
                end
            end
        end
        events_pending <= lcd_event_q.size();
    end

endmodule

// File: tb/char_lcd_nibble_sequencer_unit_tb.sv
// Testbench top for the LCD nibble sequencer: request stimulus, sink pacing and verdict.
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_unit_tb;
    import lcdns_pkg::*;

    // Codes the block must drop without emitting anything.
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int          RANDOM_PHASE_LEN = 38;    // three phases, 114 requests
    localparam int          LONG_HOLD_CYCLES = 300;   // sink hold-off that backs up the input
    localparam int          DRAIN_CYCLES     = 16;    // lets a dropped request settle
    localparam int unsigned CYCLE_LIMIT      = 300000;

    typedef enum logic [1:0] {
        SINK_FREE,      // ready every cycle
        SINK_COIN,      // ready half the time
        SINK_SLOW,      // ready one cycle in four
        SINK_EVERY3     // ready on a fixed one-in-three beat
    } sink_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int unsigned fail_total;
    int unsigned events_pending;
    int unsigned cycle_count;
    int          burst_left;
    logic        long_hold_req;

    char_lcd_nibble_sequencer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lcd_bus_event_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_total     (fail_total),
        .events_pending (events_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost event ends the run here.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** char_lcd_nibble_sequencer_unit: FAILED **");
            $finish;
        end
    end

    // Sink pacing: random segments of different stall patterns, plus one long
    // hold-off once the stimulus asks for it. The hold-off lets the sender keep
    // offering requests while the block sits on an unaccepted event.
    initial begin : sink_pace
        sink_mode_t mode;
        int         seg_left;
        int         hold_left;
        logic       hold_done;
        mode      = SINK_FREE;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = sink_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (mode)
                    SINK_FREE:   m_tready <= 1'b1;
                    SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    SINK_SLOW:   m_tready <= ($urandom_range(0, 3) == 0);
                    SINK_EVERY3: m_tready <= (seg_left % 3 == 0);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Offer one request and hold it until the transfer; returns right after the
    // accepting edge with s_tvalid still high.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] byte_val,
                                logic [COL_W-1:0] col, logic row_sel);
        s_tdata  <= {{(S_TDATA_W-CMD_W-BYTE_W-COL_W-1){1'b0}}, row_sel, col, byte_val, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Bursts of back-to-back requests with random gaps between them; long
    // bursts give stretches with no sender idling.
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(1, 5);
        end
    endtask

    task automatic offer(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] byte_val,
                         logic [COL_W-1:0] col, logic row_sel);
        send_request(cmd, byte_val, col, row_sel);
        pace_sender();
    endtask

    // Drop valid, wait for every predicted event, then let a dropped request settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (events_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register write, after which the channel goes idle.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random request mix: mostly writes and cursor moves, some inits and
    // clears, a few spare codes that must vanish.
    task automatic random_phase(int count);
        int                pick;
        logic [CMD_W-1:0]  cmd;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       cmd = CMD_INIT;
            else if (pick < 30) cmd = CMD_INSTR;
            else if (pick < 58) cmd = CMD_DATA;
            else if (pick < 80) cmd = CMD_CURSOR;
            else if (pick < 92) cmd = CMD_CLEAR;
            else if (pick < 95) cmd = CMD_SPARE_5;
            else if (pick < 97) cmd = CMD_SPARE_6;
            else                cmd = CMD_SPARE_7;
            offer(cmd, BYTE_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_ENABLE_HIGH;
        cfg_data      <= '0;
        long_hold_req <= 1'b0;
        burst_left    = 3;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every command, byte and cursor extremes, spare codes.
        offer(CMD_INIT, 8'h00, 6'd0, 1'b0);
        offer(CMD_INSTR, 8'h00, 6'd0, 1'b0);
        offer(CMD_INSTR, 8'hFF, 6'd63, 1'b1);
        offer(CMD_INSTR, 8'hA5, 6'd0, 1'b0);
        offer(CMD_DATA, 8'h00, 6'd0, 1'b0);
        offer(CMD_DATA, 8'hFF, 6'd0, 1'b0);
        offer(CMD_DATA, 8'h5A, 6'd42, 1'b1);
        offer(CMD_CURSOR, 8'h00, 6'd0, 1'b0);
        offer(CMD_CURSOR, 8'hFF, 6'd63, 1'b0);
        offer(CMD_CURSOR, 8'h00, 6'd0, 1'b1);
        offer(CMD_CURSOR, 8'h00, 6'd63, 1'b1);
        offer(CMD_CURSOR, 8'h33, 6'd21, 1'b1);
        offer(CMD_CLEAR, 8'hFF, 6'd63, 1'b1);
        offer(CMD_SPARE_5, 8'hFF, 6'd63, 1'b1);
        offer(CMD_SPARE_6, 8'h00, 6'd0, 1'b0);
        offer(CMD_SPARE_7, 8'h81, 6'd17, 1'b1);
        offer(CMD_CLEAR, 8'h00, 6'd0, 1'b0);
        offer(CMD_INIT, 8'hFF, 6'd63, 1'b1);
        drain();

        // Lowest timing settings; hold the sink off while requests pile up.
        write_register(CFG_ENABLE_HIGH, 10'd1);
        write_register(CFG_STROBE_REC, 10'd1);
        long_hold_req <= 1'b1;
        random_phase(RANDOM_PHASE_LEN);
        drain();

        // Highest timing settings.
        write_register(CFG_ENABLE_HIGH, 10'd255);
        write_register(CFG_STROBE_REC, 10'd1023);
        random_phase(RANDOM_PHASE_LEN);
        drain();

        // Arbitrary legal settings.
        write_register(CFG_STROBE_REC, CFG_DAT_W'($urandom_range(1, 1023)));
        write_register(CFG_ENABLE_HIGH, CFG_DAT_W'($urandom_range(1, 255)));
        random_phase(RANDOM_PHASE_LEN);
        drain();

        if (fail_total == 0)
            $display("** char_lcd_nibble_sequencer_unit: PASSED **");
        else
            $display("** char_lcd_nibble_sequencer_unit: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
design/lcdns_pkg.sv
design/lcdns_ctrl.sv
design/lcdns_datapath.sv
design/char_lcd_nibble_sequencer_unit.sv
tb/lcd_bus_event_checker.sv
tb/char_lcd_nibble_sequencer_unit_tb.sv
